@@ hdl/running_top_k_quantile_bounds_top_defines.svh @@
// ---------------------------------------------------------------------------
// Running top-k bounds: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef RUNNING_TOP_K_QUANTILE_BOUNDS_TOP_DEFINES_SVH
`define RUNNING_TOP_K_QUANTILE_BOUNDS_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTKQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTKQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rtkq_pkg.sv @@
// ---------------------------------------------------------------------------
// Running top-k bounds package
// Field widths, register indexes, state types and shared structs.
// ---------------------------------------------------------------------------
package rtkq_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int SERIES_IDX_W   = 4;
  localparam int NUM_SERIES_W   = 5;
  localparam int KEEP_W         = 8;
  localparam int STRIP_W_W      = 5;
  localparam int STRIP_CNT_W    = 7;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 8;

  localparam int SERIES_MAX_DEF = 16;
  localparam int KEEP_MAX_DEF   = 128;
  localparam int STRIPS_MAX_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SERIES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = CFG_IDX_W'(1);

  localparam logic [NUM_SERIES_W-1:0] NUM_SERIES_RST = NUM_SERIES_W'(1);
  localparam logic [KEEP_W-1:0]       KEEP_COUNT_RST = KEEP_W'(128);

  // Side 0 keeps the largest samples (minimum tracked), side 1 the smallest.
  localparam logic SIDE_HIGH = 1'b0;
  localparam logic SIDE_LOW  = 1'b1;

  typedef enum logic [1:0] {LAY_IDLE, LAY_SQ, LAY_DIV} lay_state_t;

  typedef enum logic [3:0] {
    CS_IDLE, CS_FILL0, CS_FILL1, CS_SETUP, CS_SCAN_RD, CS_SCAN_LAST, CS_SCAN_WR,
    CS_STRIPS_RD, CS_STRIPS_LAST, CS_BND_WR, CS_BND_RD, CS_BND_CMP, CS_POS_RD,
    CS_REPL_WR, CS_DONE
  } core_state_t;

  typedef struct packed {
    logic [STRIP_W_W-1:0]   width;
    logic [STRIP_CNT_W-1:0] count;
  } layout_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] upper;
    logic signed [SAMPLE_W-1:0] lower;
    logic                       ready;
  } result_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ hdl/rtkq_if.sv @@
// ---------------------------------------------------------------------------
// Running top-k bounds channel interfaces
// Sample input, bounds result and register write channels.
// ---------------------------------------------------------------------------
interface rtkq_in_if import rtkq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [SERIES_IDX_W-1:0]    series_index;
  modport source (output valid, sample, series_index, input ready);
  modport sink   (input valid, sample, series_index, output ready);
endinterface

interface rtkq_out_if import rtkq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] upper_bound;
  logic signed [SAMPLE_W-1:0] lower_bound;
  logic                       bounds_ready;
  modport source (output valid, upper_bound, lower_bound, bounds_ready, input ready);
  modport sink   (input valid, upper_bound, lower_bound, bounds_ready, output ready);
endinterface

interface rtkq_cfg_if import rtkq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/rtkq_cmp.sv @@
// ---------------------------------------------------------------------------
// Running top-k bounds comparator
// Shared signed compare; the side selects which direction counts as better.
// ---------------------------------------------------------------------------
module rtkq_cmp import rtkq_pkg::*; (
  input  logic                       side,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  output logic                       better
);

  // High side tracks a minimum, low side a maximum.
  always_comb begin
    if (side == SIDE_HIGH) begin
      better = (a < b);
    end else begin
      better = (a > b);
    end
  end

endmodule

@@ hdl/rtkq_layout.sv @@
// ---------------------------------------------------------------------------
// Running top-k bounds strip layout
// Iterates to width ceil(sqrt(k)) and count min(floor(k/width), STRIPS_MAX).
// ---------------------------------------------------------------------------
module rtkq_layout import rtkq_pkg::*; #(
  parameter int STRIPS_MAX = STRIPS_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic [KEEP_W-1:0] k,
  output layout_t           lay,
  output logic              busy
);

  lay_state_t             st_r, st_nxt;
  logic [STRIP_W_W-1:0]   w_r, w_nxt;
  logic [STRIP_CNT_W-1:0] n_r, n_nxt;
  logic [KEEP_W:0]        acc_r, acc_nxt;
  logic [2*STRIP_W_W-1:0] sq;
  logic [KEEP_W:0]        sum;
  logic                   grow_w;
  logic                   grow_n;

  assign sq     = w_r * w_r;
  assign sum    = acc_r + (KEEP_W+1)'(w_r);
  assign grow_w = ((2*STRIP_W_W)'(k) > sq);
  assign grow_n = (sum <= {1'b0, k}) && (32'(n_r) < STRIPS_MAX);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      LAY_IDLE: st_nxt = LAY_IDLE;
      LAY_SQ:   if (!grow_w) st_nxt = LAY_DIV;
      LAY_DIV:  if (!grow_n) st_nxt = LAY_IDLE;
      default:  st_nxt = LAY_IDLE;
    endcase
    if (restart) st_nxt = LAY_SQ;
  end

  always_comb begin
    w_nxt   = w_r;
    n_nxt   = n_r;
    acc_nxt = acc_r;
    unique case (st_r)
      LAY_SQ: begin
        if (grow_w) begin
          w_nxt = w_r + STRIP_W_W'(1);
        end else begin
          n_nxt   = '0;
          acc_nxt = '0;
        end
      end
      LAY_DIV: begin
        if (grow_n) begin
          acc_nxt = sum;
          n_nxt   = n_r + STRIP_CNT_W'(1);
        end
      end
      default: ;
    endcase
    if (restart) w_nxt = STRIP_W_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LAY_SQ;
      w_r  <= STRIP_W_W'(1);
    end else begin
      st_r <= st_nxt;
      w_r  <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    acc_r <= acc_nxt;
  end

  assign lay.width = w_r;
  assign lay.count = n_r;
  assign busy      = (st_r != LAY_IDLE);

endmodule

@@ hdl/rtkq_core.sv @@
// ---------------------------------------------------------------------------
// Running top-k bounds core
// Sequencer, sample stores, strip caches and bound table around one comparator.
// ---------------------------------------------------------------------------
module rtkq_core import rtkq_pkg::*; #(
  parameter int SERIES_MAX = SERIES_MAX_DEF,
  parameter int KEEP_MAX   = KEEP_MAX_DEF,
  parameter int STRIPS_MAX = STRIPS_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic [SERIES_IDX_W-1:0]    in_series,
  input  logic                       in_hit,
  input  logic [NUM_SERIES_W-1:0]    ns,
  input  logic [KEEP_W-1:0]          k,
  input  layout_t                    lay,
  input  logic                       fill_clr,
  input  logic                       res_take,
  output logic                       idle,
  output logic                       res_valid,
  output result_t                    res
);

  localparam int SW     = addr_w(SERIES_MAX);
  localparam int KW     = addr_w(KEEP_MAX);
  localparam int SJW    = addr_w(STRIPS_MAX);
  localparam int PW     = KW;
  localparam int ST_AW  = 1 + SW + KW;
  localparam int SP_AW  = 1 + SW + SJW;
  localparam int BN_AW  = 1 + SW;
  localparam int SP_DW  = SAMPLE_W + PW;
  localparam int BN_DW  = SAMPLE_W + SJW;

  // Memories: both sides share one array each, side is the top address bit.
  logic [SAMPLE_W-1:0] st_mem [0:(2**ST_AW)-1];
  logic [SP_DW-1:0]    sp_mem [0:(2**SP_AW)-1];
  logic [BN_DW-1:0]    bn_mem [0:(2**BN_AW)-1];

  logic                st_we, sp_we, bn_we;
  logic [ST_AW-1:0]    st_wa, st_ra;
  logic [SP_AW-1:0]    sp_wa, sp_ra;
  logic [BN_AW-1:0]    bn_a;
  logic [SAMPLE_W-1:0] st_rd_r;
  logic [SP_DW-1:0]    sp_rd_r;
  logic [BN_DW-1:0]    bn_rd_r;
  logic [SP_DW-1:0]    sp_wd;
  logic [BN_DW-1:0]    bn_wd;

  core_state_t                state_r, state_nxt;
  logic [KEEP_W-1:0]          fill_r, fill_nxt;
  logic signed [SAMPLE_W-1:0] v_r, v_nxt;
  logic [SW-1:0]              s_r, s_nxt;
  logic [SW-1:0]              t_r, t_nxt;
  logic                       side_r, side_nxt;
  logic                       upd_r, upd_nxt;
  logic [SJW-1:0]             j_r, j_nxt;
  logic [KEEP_W-1:0]          base_r, base_nxt;
  logic [KEEP_W-1:0]          len_r, len_nxt;
  logic [KEEP_W-1:0]          i_r, i_nxt;
  logic [KEEP_W-1:0]          pq_r, pq_nxt;
  logic                       rv_r, rv_nxt;
  logic                       first_r, first_nxt;
  logic signed [SAMPLE_W-1:0] best_val_r, best_val_nxt;
  logic [KEEP_W-1:0]          best_idx_r, best_idx_nxt;
  logic [KEEP_W-1:0]          pos_r, pos_nxt;
  logic signed [SAMPLE_W-1:0] up_r, up_nxt;
  logic signed [SAMPLE_W-1:0] lo_r, lo_nxt;
  logic                       rdy_r, rdy_nxt;

  logic signed [SAMPLE_W-1:0] bnd_val;
  logic [SJW-1:0]             bnd_j;
  logic signed [SAMPLE_W-1:0] sp_val;
  logic [PW-1:0]              sp_pos;
  logic signed [SAMPLE_W-1:0] cmp_a, cmp_b;
  logic                       better, take;
  logic                       s_last, t_last, j_last, fill_done;
  logic [NUM_SERIES_W-1:0]    ns_m1;
  logic [STRIP_CNT_W-1:0]     n_m1;
  logic [KEEP_W-1:0]          fill_inc;
  logic [KEEP_W-1:0]          slot;

  assign bnd_val   = bn_rd_r[BN_DW-1 -: SAMPLE_W];
  assign bnd_j     = bn_rd_r[SJW-1:0];
  assign sp_val    = sp_rd_r[SP_DW-1 -: SAMPLE_W];
  assign sp_pos    = sp_rd_r[PW-1:0];
  assign ns_m1     = ns - NUM_SERIES_W'(1);
  assign n_m1      = lay.count - STRIP_CNT_W'(1);
  assign s_last    = (NUM_SERIES_W'(s_r) == ns_m1);
  assign t_last    = (NUM_SERIES_W'(t_r) == ns_m1);
  assign j_last    = (STRIP_CNT_W'(j_r) == n_m1);
  assign fill_inc  = fill_r + KEEP_W'(1);
  assign fill_done = (fill_inc == k);
  assign slot      = base_r + i_r;

  // One comparator serves the bound check and both scan loops.
  always_comb begin
    if (state_r == CS_BND_CMP) begin
      cmp_a = bnd_val;
      cmp_b = v_r;
    end else if (state_r == CS_STRIPS_RD || state_r == CS_STRIPS_LAST) begin
      cmp_a = sp_val;
      cmp_b = best_val_r;
    end else begin
      cmp_a = st_rd_r;
      cmp_b = best_val_r;
    end
  end

  rtkq_cmp u_cmp (
    .side   (side_r),
    .a      (cmp_a),
    .b      (cmp_b),
    .better (better)
  );

  assign take = first_r || better;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          if (!in_hit) state_nxt = CS_DONE;
          else if (fill_r < k) state_nxt = CS_FILL0;
          else state_nxt = CS_BND_RD;
        end
      end
      CS_FILL0:       state_nxt = CS_FILL1;
      CS_FILL1:       state_nxt = (s_last && fill_done) ? CS_SETUP : CS_DONE;
      CS_SETUP:       state_nxt = CS_SCAN_RD;
      CS_SCAN_RD:     if (i_r == len_r - KEEP_W'(1)) state_nxt = CS_SCAN_LAST;
      CS_SCAN_LAST:   state_nxt = CS_SCAN_WR;
      CS_SCAN_WR:     state_nxt = (upd_r || j_last) ? CS_STRIPS_RD : CS_SETUP;
      CS_STRIPS_RD:   if (i_r == KEEP_W'(n_m1)) state_nxt = CS_STRIPS_LAST;
      CS_STRIPS_LAST: state_nxt = CS_BND_WR;
      CS_BND_WR: begin
        if (upd_r) state_nxt = (side_r == SIDE_LOW) ? CS_DONE : CS_BND_RD;
        else if (side_r == SIDE_LOW && t_last) state_nxt = CS_BND_RD;
        else state_nxt = CS_SETUP;
      end
      CS_BND_RD:      state_nxt = CS_BND_CMP;
      CS_BND_CMP: begin
        if (upd_r && better) state_nxt = CS_POS_RD;
        else state_nxt = (side_r == SIDE_LOW) ? CS_DONE : CS_BND_RD;
      end
      CS_POS_RD:      state_nxt = CS_REPL_WR;
      CS_REPL_WR:     state_nxt = CS_SETUP;
      CS_DONE:        if (res_take) state_nxt = CS_IDLE;
      default:        state_nxt = CS_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    fill_nxt     = fill_r;
    v_nxt        = v_r;
    s_nxt        = s_r;
    t_nxt        = t_r;
    side_nxt     = side_r;
    upd_nxt      = upd_r;
    j_nxt        = j_r;
    base_nxt     = base_r;
    len_nxt      = len_r;
    i_nxt        = i_r;
    pq_nxt       = pq_r;
    rv_nxt       = rv_r;
    first_nxt    = first_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    pos_nxt      = pos_r;
    up_nxt       = up_r;
    lo_nxt       = lo_r;
    rdy_nxt      = rdy_r;
    st_we        = 1'b0;
    sp_we        = 1'b0;
    bn_we        = 1'b0;
    st_wa        = {side_r, t_r, KW'(slot)};
    st_ra        = {side_r, t_r, KW'(slot)};
    sp_wa        = {side_r, t_r, j_r};
    sp_ra        = {side_r, t_r, SJW'(i_r)};
    bn_a         = {side_r, t_r};
    sp_wd        = {best_val_r, PW'(best_idx_r)};
    bn_wd        = {best_val_r, SJW'(best_idx_r)};

    if ((state_r == CS_SCAN_RD || state_r == CS_SCAN_LAST ||
         state_r == CS_STRIPS_RD || state_r == CS_STRIPS_LAST) && rv_r && take) begin
      best_val_nxt = cmp_a;
      best_idx_nxt = pq_r;
      first_nxt    = 1'b0;
    end

    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          v_nxt    = in_sample;
          s_nxt    = SW'(in_series);
          t_nxt    = SW'(in_series);
          side_nxt = SIDE_HIGH;
          upd_nxt  = 1'b1;
          up_nxt   = '0;
          lo_nxt   = '0;
          rdy_nxt  = in_hit && !(fill_r < k);
        end
      end
      CS_FILL0: begin
        st_we = 1'b1;
        st_wa = {SIDE_HIGH, s_r, KW'(fill_r)};
      end
      CS_FILL1: begin
        st_we = 1'b1;
        st_wa = {SIDE_LOW, s_r, KW'(fill_r)};
        if (s_last) begin
          fill_nxt = fill_inc;
          if (fill_done) begin
            upd_nxt  = 1'b0;
            t_nxt    = '0;
            side_nxt = SIDE_HIGH;
            j_nxt    = '0;
            base_nxt = '0;
          end
        end
      end
      CS_SETUP: begin
        len_nxt   = j_last ? (k - base_r) : KEEP_W'(lay.width);
        i_nxt     = '0;
        rv_nxt    = 1'b0;
        first_nxt = 1'b1;
      end
      CS_SCAN_RD, CS_STRIPS_RD: begin
        rv_nxt = 1'b1;
        pq_nxt = i_r;
        i_nxt  = i_r + KEEP_W'(1);
      end
      CS_SCAN_LAST, CS_STRIPS_LAST: begin
        rv_nxt = 1'b0;
      end
      CS_SCAN_WR: begin
        sp_we     = 1'b1;
        i_nxt     = '0;
        rv_nxt    = 1'b0;
        first_nxt = 1'b1;
        if (!upd_r && !j_last) begin
          j_nxt    = j_r + SJW'(1);
          base_nxt = base_r + KEEP_W'(lay.width);
        end
      end
      CS_BND_WR: begin
        bn_we = 1'b1;
        if (upd_r) begin
          if (side_r == SIDE_HIGH) begin
            up_nxt   = best_val_r;
            side_nxt = SIDE_LOW;
          end else begin
            lo_nxt = best_val_r;
          end
        end else begin
          j_nxt    = '0;
          base_nxt = '0;
          if (side_r == SIDE_HIGH) begin
            side_nxt = SIDE_LOW;
          end else if (t_last) begin
            // Whole table refreshed: read back this item's bounds.
            side_nxt = SIDE_HIGH;
            t_nxt    = s_r;
            rdy_nxt  = 1'b1;
          end else begin
            side_nxt = SIDE_HIGH;
            t_nxt    = t_r + SW'(1);
          end
        end
      end
      CS_BND_CMP: begin
        sp_ra = {side_r, t_r, bnd_j};
        if (upd_r && better) begin
          j_nxt = bnd_j;
        end else begin
          if (side_r == SIDE_HIGH) begin
            up_nxt   = bnd_val;
            side_nxt = SIDE_LOW;
          end else begin
            lo_nxt = bnd_val;
          end
        end
      end
      CS_POS_RD: begin
        base_nxt = KEEP_W'(j_r) * KEEP_W'(lay.width);
        pos_nxt  = KEEP_W'(sp_pos);
      end
      CS_REPL_WR: begin
        st_we = 1'b1;
        st_wa = {side_r, t_r, KW'(base_r + pos_r)};
      end
      default: ;
    endcase

    if (fill_clr) fill_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    s_r        <= s_nxt;
    t_r        <= t_nxt;
    side_r     <= side_nxt;
    upd_r      <= upd_nxt;
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    len_r      <= len_nxt;
    i_r        <= i_nxt;
    pq_r       <= pq_nxt;
    rv_r       <= rv_nxt;
    first_r    <= first_nxt;
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
    pos_r      <= pos_nxt;
    up_r       <= up_nxt;
    lo_r       <= lo_nxt;
    rdy_r      <= rdy_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= v_r;
    st_rd_r <= st_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (sp_we) sp_mem[sp_wa] <= sp_wd;
    sp_rd_r <= sp_mem[sp_ra];
  end

  always_ff @(posedge clk) begin
    if (bn_we) bn_mem[bn_a] <= bn_wd;
    bn_rd_r <= bn_mem[bn_a];
  end

  assign idle      = (state_r == CS_IDLE);
  assign res_valid = (state_r == CS_DONE);
  assign res.upper = up_r;
  assign res.lower = lo_r;
  assign res.ready = rdy_r;

endmodule

@@ hdl/running_top_k_quantile_bounds_top.sv @@
// ---------------------------------------------------------------------------
// Running top-k quantile bounds, top level
// Per-series tracking of the keep_count largest and smallest samples.
// ---------------------------------------------------------------------------
// Each transfer on the input channel carries one Q16.16 sample and its series
// index and yields exactly one result transfer. Until the item that completes
// keep_count rounds, the sample is only stored and the result is all zero
// with bounds_ready low. That item rescans every strip of every series and
// returns its bounds. After that, an item that moves neither bound reads and
// compares both stored bounds, and a side that is replaced also rewrites one
// sample, rescans its strip and then the strip extremes, paced by the one read
// port of the sample store and the single shared comparator. A series index
// at or above num_series is answered with zeros and changes nothing. After
// reset and after every register write the block computes its strip layout
// with input ready low; writes to num_series or keep_count restart the fill.
// ---------------------------------------------------------------------------
`include "running_top_k_quantile_bounds_top_defines.svh"

module running_top_k_quantile_bounds_top import rtkq_pkg::*; #(
  parameter int SERIES_MAX = SERIES_MAX_DEF,
  parameter int KEEP_MAX   = KEEP_MAX_DEF,
  parameter int STRIPS_MAX = STRIPS_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rtkq_in_if.sink     in_if,
  rtkq_out_if.source  out_if,
  rtkq_cfg_if.sink    cfg_if
);

  logic [NUM_SERIES_W-1:0] num_series_r;
  logic [KEEP_W-1:0]       keep_count_r;
  logic [NUM_SERIES_W-1:0] ns;
  logic [KEEP_W-1:0]       k;
  logic                    cfg_fire;
  logic                    cfg_hit;
  logic                    in_fire;
  logic                    in_hit;
  layout_t                 lay;
  logic                    lay_busy;
  logic                    core_idle;
  logic                    core_res_vld;
  result_t                 core_res;
  logic                    res_take;
  logic                    out_valid_r;
  result_t                 out_res_r;

  // Never stalls; writes must arrive only while the block is idle, unenforced.
  assign cfg_if.ready = 1'b1;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;
  assign cfg_hit      = cfg_fire &&
                        (cfg_if.index == REG_NUM_SERIES || cfg_if.index == REG_KEEP_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_series_r <= NUM_SERIES_RST;
      keep_count_r <= KEEP_COUNT_RST;
    end else if (cfg_fire) begin
      if (cfg_if.index == REG_NUM_SERIES) num_series_r <= cfg_if.data[NUM_SERIES_W-1:0];
      if (cfg_if.index == REG_KEEP_COUNT) keep_count_r <= cfg_if.data[KEEP_W-1:0];
    end
  end

  // Saturate both registers into the range the storage supports.
  always_comb begin
    if (num_series_r == '0) ns = NUM_SERIES_W'(1);
    else if (32'(num_series_r) > SERIES_MAX) ns = NUM_SERIES_W'(SERIES_MAX);
    else ns = num_series_r;
    if (keep_count_r == '0) k = KEEP_W'(1);
    else if (32'(keep_count_r) > KEEP_MAX) k = KEEP_W'(KEEP_MAX);
    else k = keep_count_r;
  end

  rtkq_layout #(
    .STRIPS_MAX (STRIPS_MAX)
  ) u_layout (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_fire),
    .k       (k),
    .lay     (lay),
    .busy    (lay_busy)
  );

  // Input is taken only while the sequencer is idle and the layout is settled.
  assign in_if.ready = core_idle && !lay_busy;
  assign in_fire     = in_if.valid && in_if.ready;
  assign in_hit      = ({1'b0, in_if.series_index} < ns);

  rtkq_core #(
    .SERIES_MAX (SERIES_MAX),
    .KEEP_MAX   (KEEP_MAX),
    .STRIPS_MAX (STRIPS_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .in_sample (in_if.sample),
    .in_series (in_if.series_index),
    .in_hit    (in_hit),
    .ns        (ns),
    .k         (k),
    .lay       (lay),
    .fill_clr  (cfg_hit),
    .res_take  (res_take),
    .idle      (core_idle),
    .res_valid (core_res_vld),
    .res       (core_res)
  );

  // Output register: the core hands over its result as soon as the slot frees,
  // so a new sample can be worked on while the previous result waits.
  assign res_take = core_res_vld && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) out_res_r <= core_res;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.upper_bound  = out_res_r.upper;
  assign out_if.lower_bound  = out_res_r.lower;
  assign out_if.bounds_ready = out_res_r.ready;

  // The sequencer leaves idle on every accepted sample.
  `RTKQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_if.ready, "input ready after accept")
  // A register write recomputes the layout, which blocks input meanwhile.
  `RTKQ_ASSERT_NEXT(a_cfg_blocks_input, clk, rst_n, cfg_fire, !in_if.ready, "input ready after write")
  // Results without valid bounds carry zero bounds.
  `RTKQ_ASSERT_SAME(a_zero_when_not_ready, clk, rst_n, out_if.valid && !out_if.bounds_ready, out_if.upper_bound == 0 && out_if.lower_bound == 0, "nonzero bound while not ready")
  // A result handed over by the core shows up on the output next cycle.
  `RTKQ_ASSERT_NEXT(a_result_lands, clk, rst_n, res_take, out_if.valid, "result lost")

endmodule

@@ bench/running_top_k_quantile_bounds_top_tb.sv @@
// ---------------------------------------------------------------------------
// Running top-k quantile bounds testbench
// Drives samples through a behavioral predictor of the per-series top-k and
// bottom-k stores and checks every bounds result. It covers several register
// settings, random stalls on both channels, and a quiet closing phase.
// ---------------------------------------------------------------------------
module running_top_k_quantile_bounds_top_tb;
  import rtkq_pkg::*;

  localparam int SER_MAX   = SERIES_MAX_DEF;
  localparam int KEEP_LIM  = KEEP_MAX_DEF;
  localparam int STRIP_LIM = STRIPS_MAX_DEF;

  logic clk;
  logic rst_n;

  rtkq_in_if  in_ch ();
  rtkq_out_if out_ch ();
  rtkq_cfg_if cfg_ch ();

  running_top_k_quantile_bounds_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock with a period of 8 time units.
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Predictor state: one copy of each store and of the strip extremes.
  int signed high_keep [SER_MAX][KEEP_LIM];
  int signed low_keep  [SER_MAX][KEEP_LIM];
  int signed strip_lo_val [SER_MAX][STRIP_LIM];
  int        strip_lo_pos [SER_MAX][STRIP_LIM];
  int signed strip_hi_val [SER_MAX][STRIP_LIM];
  int        strip_hi_pos [SER_MAX][STRIP_LIM];
  int signed upper_of [SER_MAX];
  int signed lower_of [SER_MAX];
  int        upper_strip [SER_MAX];
  int        lower_strip [SER_MAX];
  int        rounds_filled;
  int        series_reg;
  int        keep_reg;

  result_t bounds_due [$];
  int      error_count;
  int      samples_sent;
  int      results_seen;
  int      settings_run;
  bit      quiet;

  function automatic int series_used();
    if (series_reg < 1) return 1;
    if (series_reg > SER_MAX) return SER_MAX;
    return series_reg;
  endfunction

  function automatic int keep_used();
    if (keep_reg < 1) return 1;
    if (keep_reg > KEEP_LIM) return KEEP_LIM;
    return keep_reg;
  endfunction

  // Strips are ceil(sqrt(k)) wide; the last one takes whatever is left.
  function automatic void strip_geometry(output int w, output int n);
    int k;
    k = keep_used();
    w = 1;
    while (w * w < k) w++;
    n = k / w;
    if (n < 1) n = 1;
    if (n > STRIP_LIM) n = STRIP_LIM;
  endfunction

  function automatic int strip_len(int j, int w, int n);
    return (j + 1 == n) ? keep_used() - j * w : w;
  endfunction

  // Rescan one strip. The high side tracks its minimum, the low side its
  // maximum; ties keep the lowest position.
  function automatic void rescan_strip(int s, int j, logic side);
    int w, n, len, best_pos;
    int signed best, x;
    strip_geometry(w, n);
    len = strip_len(j, w, n);
    best = (side == SIDE_HIGH) ? high_keep[s][j*w] : low_keep[s][j*w];
    best_pos = 0;
    for (int i = 1; i < len; i++) begin
      x = (side == SIDE_HIGH) ? high_keep[s][j*w+i] : low_keep[s][j*w+i];
      if ((side == SIDE_HIGH) ? (x < best) : (x > best)) begin
        best = x;
        best_pos = i;
      end
    end
    if (side == SIDE_HIGH) begin
      strip_lo_val[s][j] = best;
      strip_lo_pos[s][j] = best_pos;
    end else begin
      strip_hi_val[s][j] = best;
      strip_hi_pos[s][j] = best_pos;
    end
  endfunction

  function automatic void rescan_bound(int s, logic side);
    int w, n, best_j;
    int signed best, x;
    strip_geometry(w, n);
    best = (side == SIDE_HIGH) ? strip_lo_val[s][0] : strip_hi_val[s][0];
    best_j = 0;
    for (int j = 1; j < n; j++) begin
      x = (side == SIDE_HIGH) ? strip_lo_val[s][j] : strip_hi_val[s][j];
      if ((side == SIDE_HIGH) ? (x < best) : (x > best)) begin
        best = x;
        best_j = j;
      end
    end
    if (side == SIDE_HIGH) begin
      upper_of[s] = best;
      upper_strip[s] = best_j;
    end else begin
      lower_of[s] = best;
      lower_strip[s] = best_j;
    end
  endfunction

  function automatic void swap_out_extreme(int s, int signed v, logic side);
    int w, n, j, p;
    strip_geometry(w, n);
    if (side == SIDE_HIGH) begin
      j = upper_strip[s] % n;
      p = strip_lo_pos[s][j] % strip_len(j, w, n);
      high_keep[s][j*w+p] = v;
    end else begin
      j = lower_strip[s] % n;
      p = strip_hi_pos[s][j] % strip_len(j, w, n);
      low_keep[s][j*w+p] = v;
    end
    rescan_strip(s, j, side);
    rescan_bound(s, side);
  endfunction

  function automatic result_t next_bounds(int signed v, int s);
    result_t r;
    int ns, k, w, n;
    ns = series_used();
    k = keep_used();
    r = '0;
    if (s >= ns) return r;
    if (rounds_filled < k) begin
      high_keep[s][rounds_filled] = v;
      low_keep[s][rounds_filled] = v;
      if (s + 1 == ns) begin
        rounds_filled++;
        if (rounds_filled == k) begin
          strip_geometry(w, n);
          for (int t = 0; t < ns; t++) begin
            for (int j = 0; j < n; j++) begin
              rescan_strip(t, j, SIDE_HIGH);
              rescan_strip(t, j, SIDE_LOW);
            end
            rescan_bound(t, SIDE_HIGH);
            rescan_bound(t, SIDE_LOW);
          end
        end
      end
    end else begin
      if (v > upper_of[s]) swap_out_extreme(s, v, SIDE_HIGH);
      if (v < lower_of[s]) swap_out_extreme(s, v, SIDE_LOW);
    end
    if (rounds_filled >= k) begin
      r.upper = upper_of[s];
      r.lower = lower_of[s];
      r.ready = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result checker: compares each transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (bounds_due.size() == 0) begin
        $display("MISMATCH unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        want = bounds_due.pop_front();
        if (out_ch.upper_bound !== want.upper)
          report("upper_bound", out_ch.upper_bound, want.upper);
        if (out_ch.lower_bound !== want.lower)
          report("lower_bound", out_ch.lower_bound, want.lower);
        if (out_ch.bounds_ready !== want.ready)
          report("bounds_ready", out_ch.bounds_ready, want.ready);
      end
    end
  end

  // Receiver stalls come in random bursts, except in the quiet phase.
  int stall_left;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task automatic send_sample(logic [31:0] v, logic [3:0] idx);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= v;
    in_ch.series_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    bounds_due.push_back(next_bounds(v, idx));
    samples_sent++;
    @(negedge clk);
  endtask

  // Lower valid and wait until every expected result has come back, then a
  // short settling gap.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (bounds_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_NUM_SERIES) series_reg = val & 8'h1F;
    else if (idx == REG_KEEP_COUNT) keep_reg = val;
    rounds_filled = 0;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [7:0] ns, logic [7:0] k);
    drain();
    write_reg(REG_NUM_SERIES, ns);
    write_reg(REG_KEEP_COUNT, k);
    settings_run++;
  endtask

  // Half are narrow values so ties and replacements are common; the rest span
  // the whole range and hit both extremes.
  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // Complete fill: every series in each round, the last series closing it,
  // with occasional repeats and ignored indexes mixed in.
  task automatic fill_all();
    int ns;
    ns = series_used();
    for (int r = 0; r < keep_used(); r++) begin
      for (int s = 0; s < ns; s++) begin
        send_sample(pick_sample(), 4'(s));
        if ($urandom_range(0, 9) == 0 && s + 1 < ns) send_sample(pick_sample(), 4'(s));
        if ($urandom_range(0, 14) == 0 && ns < SER_MAX)
          send_sample(pick_sample(), 4'($urandom_range(ns, SER_MAX - 1)));
      end
    end
  endtask

  task automatic run_random(int count);
    int ns;
    ns = series_used();
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0 && ns < SER_MAX)
        send_sample(pick_sample(), 4'($urandom_range(ns, SER_MAX - 1)));
      else
        send_sample(pick_sample(), 4'($urandom_range(0, ns - 1)));
    end
  endtask

  // Reset values: a long fill is pending, so results stay zero.
  task automatic test_reset_defaults();
    send_sample(32'h0001_0000, 4'd0);
    send_sample(32'hFFFF_0000, 4'd0);
    send_sample(32'h1234_5678, 4'd15);
  endtask

  // Hand-picked items on tiny stores: extremes, equal values, ignored indexes.
  task automatic test_directed();
    configure(8'd2, 8'd0);
    send_sample(32'hFFFF_FFFB, 4'd0);
    send_sample(32'h0000_0007, 4'd1);
    send_sample(32'h7FFF_FFFF, 4'd0);
    send_sample(32'h8000_0000, 4'd0);
    send_sample(32'h0000_0007, 4'd1);
    send_sample(32'hFFFF_FFFF, 4'd1);
    send_sample(32'h0000_0000, 4'd2);
    send_sample(32'hFFFF_FFFF, 4'd15);
    configure(8'd2, 8'd4);
    for (int r = 0; r < 4; r++) begin
      send_sample(r[0] ? 32'h7FFF_FFFF : 32'h8000_0000, 4'd0);
      send_sample(32'(r), 4'd1);
    end
    send_sample(32'h0000_0002, 4'd1);
    send_sample(32'h8000_0000, 4'd1);
    send_sample(32'h7FFF_FFFF, 4'd1);
    send_sample(32'h0000_0000, 4'd0);
  endtask

  // Upper saturation of num_series with the smallest store.
  task automatic test_series_extremes();
    configure(8'hFF, 8'd1);
    fill_all();
    run_random(6);
  endtask

  // Largest store, num_series written as zero so it saturates to one.
  task automatic test_keep_max();
    configure(8'hE0, 8'hFF);
    fill_all();
    run_random(6);
  endtask

  task automatic test_random_settings();
    int ns_list [6] = '{3, 4, 1, 2, 5, 16};
    int k_list  [6] = '{5, 6, 22, 8, 3, 2};
    for (int c = 0; c < 6; c++) begin
      configure(8'(ns_list[c]), 8'(k_list[c]));
      fill_all();
      run_random(6);
      // Let the result queue run dry once mid-phase before carrying on.
      if (c == 1) drain();
      run_random(6);
    end
  endtask

  // Closing phase with no idling on either side.
  task automatic test_quiet_tail();
    configure(8'd2, 8'd9);
    quiet = 1'b1;
    fill_all();
    run_random(15);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.series_index = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    stall_left = 0;
    quiet = 1'b0;
    error_count = 0;
    samples_sent = 0;
    results_seen = 0;
    settings_run = 0;
    series_reg = NUM_SERIES_RST;
    keep_reg = KEEP_COUNT_RST;
    rounds_filled = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_directed();
    test_series_extremes();
    test_keep_max();
    test_random_settings();
    test_quiet_tail();

    drain();
    repeat (50) @(negedge clk);
    $display("Sent %0d samples over %0d register settings; %0d results checked.",
             samples_sent, settings_run, results_seen);
    if (error_count == 0) begin
      $display("running_top_k_quantile_bounds_top_tb: PASS");
    end else begin
      $display("Mismatches: %0d", error_count);
      $display("running_top_k_quantile_bounds_top_tb: FAIL");
    end
    $finish;
  end

  // Generous watchdog well beyond the slowest correct run.
  initial begin
    #8000000;
    $display("Timeout with %0d results outstanding.", bounds_due.size());
    $display("running_top_k_quantile_bounds_top_tb: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/rtkq_pkg.sv
hdl/rtkq_if.sv
hdl/rtkq_cmp.sv
hdl/rtkq_layout.sv
hdl/rtkq_core.sv
hdl/running_top_k_quantile_bounds_top.sv
bench/running_top_k_quantile_bounds_top_tb.sv
